// ----- hw/rtl/last_touch_attribution_aggregator_top_macros.svh -----
// assertion helpers shared by the rtl, sampled on clk and disabled while rst_n is low
`ifndef LAST_TOUCH_ATTRIBUTION_AGGREGATOR_TOP_MACROS_SVH
`define LAST_TOUCH_ATTRIBUTION_AGGREGATOR_TOP_MACROS_SVH

// same-cycle implication
`define LTA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lta_pkg.sv -----
`timescale 1ns / 1ps

package lta_pkg;

    localparam int NUM_CAMPAIGNS_DEF = 16;
    localparam int KEY_SLOTS_DEF     = 64;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 16;
    localparam int CAMP_W  = 6;
    localparam int COUNT_W = 7;
    localparam int TOTAL_W = 48;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic key_rd;
        logic scan_inc;
        logic found_set;
        logic src_write;
        logic drop_set;
        logic sum_rd;
        logic sum_wr;
        logic out_rd;
        logic out_emit;
        logic out_inc;
        logic batch_clear;
    } lta_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_empty;
        logic table_full;
        logic key_hit;
        logic scan_last;
        logic found;
        logic found_bad;
        logic src_bad;
        logic trig;
        logic eob;
        logic out_last;
    } lta_status_t;

endpackage

// ----- hw/rtl/last_touch_attribution_aggregator_top.sv -----
// operation: after the start cycle busy stays high while the F keys held this batch (at most
//   KEY_SLOTS) are scanned, skipped when the table is empty and stopped at a hit, while the event
//   resolves, with a total update for a credited trigger, and through any end-of-batch readout;
//   each slot is read through the single registered read port of the key store, then compared;
//   readout emits one total word per campaign in use, never held back; no event taken while busy
// reset: asynchronous active-low, empties the key table and totals, clears the drop flag, count 16
`timescale 1ns / 1ps

module last_touch_attribution_aggregator_top
    import lta_pkg::*;
#(
    parameter int NUM_CAMPAIGNS = NUM_CAMPAIGNS_DEF,
    parameter int KEY_SLOTS     = KEY_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // event word, taken when start is high and busy is low
    input  logic               start,
    output logic               busy,
    input  logic [KEY_W-1:0]   event_key,
    input  logic               is_conversion,
    input  logic [VALUE_W-1:0] conversion_value,
    input  logic [CAMP_W-1:0]  campaign_index,
    input  logic               end_of_batch,
    // campaign count register, write only
    input  logic               campaign_count_we,
    input  logic [COUNT_W-1:0] campaign_count,
    // total words, each valid for a single cycle
    output logic               result_valid,
    output logic [CAMP_W-1:0]  campaign,
    output logic [TOTAL_W-1:0] attributed_total,
    output logic               dropped_flag,
    output logic               last_total
);

    // command and status between the sequencer and the datapath
    lta_cmd_t    cmd;
    lta_status_t status;

    // sequencer: accept, scan the key store, resolve the event, update one total for a credited trigger,
    // then on end of batch walk the totals and clear the batch state
    lta_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // datapath: latched event, key store, total store with valid bits, drop flag,
    // campaign count register and the registered output word
    lta_datapath #(
        .NUM_CAMPAIGNS (NUM_CAMPAIGNS),
        .KEY_SLOTS     (KEY_SLOTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .event_key         (event_key),
        .is_conversion     (is_conversion),
        .conversion_value  (conversion_value),
        .campaign_index    (campaign_index),
        .end_of_batch      (end_of_batch),
        .campaign_count_we (campaign_count_we),
        .campaign_count    (campaign_count),
        .cmd               (cmd),
        .status            (status),
        .result_valid      (result_valid),
        .campaign          (campaign),
        .attributed_total  (attributed_total),
        .dropped_flag      (dropped_flag),
        .last_total        (last_total)
    );

endmodule

// ----- hw/rtl/lta_ram.sv -----
`timescale 1ns / 1ps

module lta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lta_controller.sv -----
`timescale 1ns / 1ps
`include "last_touch_attribution_aggregator_top_macros.svh"

module lta_controller
    import lta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  lta_status_t status,
    output lta_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_LOOK    = 8'b0000_0010,
        S_CHECK   = 8'b0000_0100,
        S_RESOLVE = 8'b0000_1000,
        S_SUMWR   = 8'b0001_0000,
        S_OUTRD   = 8'b0010_0000,
        S_OUTWR   = 8'b0100_0000,
        S_SPARE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   credit;

    // trigger whose key has a source in a campaign still in use
    assign credit = status.trig && status.found && !status.found_bad;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (status.fill_empty)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    cmd.key_rd = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.key_hit)
                begin
                    cmd.found_set = 1'b1;
                    state_next    = S_RESOLVE;
                end
                else if (status.scan_last)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_LOOK;
                end
            end
            S_RESOLVE:
            begin
                if (status.trig)
                begin
                    if (status.found && status.found_bad)
                    begin
                        cmd.drop_set = 1'b1;
                    end
                    else if (status.found)
                    begin
                        cmd.sum_rd = 1'b1;
                    end
                end
                else if (status.src_bad)
                begin
                    cmd.drop_set = 1'b1;
                end
                else if (status.found || !status.table_full)
                begin
                    cmd.src_write = 1'b1;
                end
                else
                begin
                    cmd.drop_set = 1'b1;
                end

                if (credit)
                begin
                    state_next = S_SUMWR;
                end
                else if (status.eob)
                begin
                    state_next = S_OUTRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUMWR:
            begin
                cmd.sum_wr = 1'b1;
                state_next = status.eob ? S_OUTRD : S_IDLE;
            end
            S_OUTRD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OUTWR;
            end
            S_OUTWR:
            begin
                cmd.out_emit = 1'b1;
                if (status.out_last)
                begin
                    cmd.batch_clear = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.out_inc = 1'b1;
                    state_next  = S_OUTRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `LTA_ASSERT_NEXT(a_start_scans, start && !busy, state_reg == S_LOOK,
        "accepted word did not start the key scan")
    `LTA_ASSERT_SAME(a_sumwr_after_resolve, state_reg == S_SUMWR,
        $past(state_reg == S_RESOLVE), "total update not preceded by resolve")
    `LTA_ASSERT_NEXT(a_readout_continues, state_reg == S_OUTWR && !status.out_last,
        state_reg == S_OUTRD, "readout stopped before the last total")

endmodule

// ----- hw/rtl/lta_datapath.sv -----
`timescale 1ns / 1ps
`include "last_touch_attribution_aggregator_top_macros.svh"

module lta_datapath
    import lta_pkg::*;
#(
    parameter int NUM_CAMPAIGNS = NUM_CAMPAIGNS_DEF,
    parameter int KEY_SLOTS     = KEY_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [KEY_W-1:0]     event_key,
    input  logic                 is_conversion,
    input  logic [VALUE_W-1:0]   conversion_value,
    input  logic [CAMP_W-1:0]    campaign_index,
    input  logic                 end_of_batch,
    input  logic                 campaign_count_we,
    input  logic [COUNT_W-1:0]   campaign_count,
    input  lta_cmd_t             cmd,
    output lta_status_t          status,
    output logic                 result_valid,
    output logic [CAMP_W-1:0]    campaign,
    output logic [TOTAL_W-1:0]   attributed_total,
    output logic                 dropped_flag,
    output logic                 last_total
);

    localparam int SLOT_AW = $clog2(KEY_SLOTS);
    localparam int FILL_W  = SLOT_AW + 1;
    localparam int SUM_AW  = (NUM_CAMPAIGNS > 1) ? $clog2(NUM_CAMPAIGNS) : 1;
    localparam int SLOT_W  = CAMP_W + KEY_W;

    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_use;
    logic [KEY_W-1:0]         key_reg;
    logic                     conv_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic [CAMP_W-1:0]        camp_reg;
    logic                     eob_reg;
    logic [SLOT_AW-1:0]       scan_reg;
    logic                     found_reg;
    logic [SLOT_AW-1:0]       found_slot_reg;
    logic [CAMP_W-1:0]        found_camp_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic [NUM_CAMPAIGNS-1:0] sum_vld_reg;
    logic                     drop_reg;
    logic [CAMP_W-1:0]        rd_idx_reg;

    logic                     result_valid_reg;
    logic [CAMP_W-1:0]        campaign_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     dropped_reg;
    logic                     last_reg;

    logic [SLOT_AW-1:0]       slot_waddr;
    logic [SLOT_W-1:0]        slot_rdata;
    logic [SUM_AW-1:0]        camp_addr;
    logic [SUM_AW-1:0]        out_addr;
    logic [SUM_AW-1:0]        sum_raddr;
    logic [TOTAL_W-1:0]       sum_rdata;
    logic [TOTAL_W-1:0]       sum_prev;
    logic [TOTAL_W:0]         sum_add;
    logic [TOTAL_W-1:0]       sum_sat;
    logic [TOTAL_W-1:0]       out_total;

    // register value clamped into 1..NUM_CAMPAIGNS
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_use = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(NUM_CAMPAIGNS))
        begin
            count_use = COUNT_W'(NUM_CAMPAIGNS);
        end
        else
        begin
            count_use = count_reg;
        end
    end

    // key store: slots 0..fill-1 are live, each holds {campaign, key}
    assign slot_waddr = found_reg ? found_slot_reg : fill_reg[SLOT_AW-1:0];

    lta_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (KEY_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.src_write),
        .waddr (slot_waddr),
        .wdata ({camp_reg, key_reg}),
        .re    (cmd.key_rd),
        .raddr (scan_reg),
        .rdata (slot_rdata)
    );

    // campaign totals, entries without a valid bit read as zero
    assign camp_addr = found_camp_reg[SUM_AW-1:0];
    assign out_addr  = rd_idx_reg[SUM_AW-1:0];
    assign sum_raddr = cmd.out_rd ? out_addr : camp_addr;

    assign sum_prev = sum_vld_reg[camp_addr] ? sum_rdata : '0;
    assign sum_add  = {1'b0, sum_prev} + (TOTAL_W + 1)'(value_reg);
    assign sum_sat  = sum_add[TOTAL_W] ? TOTAL_MAX : sum_add[TOTAL_W-1:0];

    assign out_total = sum_vld_reg[out_addr] ? sum_rdata : '0;

    lta_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (NUM_CAMPAIGNS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (cmd.sum_wr),
        .waddr (camp_addr),
        .wdata (sum_sat),
        .re    (cmd.sum_rd || cmd.out_rd),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    assign status.fill_empty = (fill_reg == '0);
    assign status.table_full = (fill_reg == FILL_W'(KEY_SLOTS));
    assign status.key_hit    = (slot_rdata[KEY_W-1:0] == key_reg);
    assign status.scan_last  = ((FILL_W'(scan_reg) + FILL_W'(1)) == fill_reg);
    assign status.found      = found_reg;
    assign status.found_bad  = ({1'b0, found_camp_reg} >= count_use);
    assign status.src_bad    = ({1'b0, camp_reg} >= count_use);
    assign status.trig       = conv_reg;
    assign status.eob        = eob_reg;
    assign status.out_last   = ((COUNT_W'(rd_idx_reg) + COUNT_W'(1)) == count_use);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= COUNT_RESET;
            fill_reg         <= '0;
            sum_vld_reg      <= '0;
            drop_reg         <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (campaign_count_we)
            begin
                count_reg <= campaign_count;
            end
            if (cmd.latch)
            begin
                found_reg <= 1'b0;
            end
            if (cmd.found_set)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.src_write && !found_reg)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.drop_set)
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.sum_wr)
            begin
                sum_vld_reg[camp_addr] <= 1'b1;
            end
            result_valid_reg <= cmd.out_emit;
            if (cmd.batch_clear)
            begin
                fill_reg    <= '0;
                sum_vld_reg <= '0;
                drop_reg    <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            key_reg    <= event_key;
            conv_reg   <= is_conversion;
            value_reg  <= conversion_value;
            camp_reg   <= campaign_index;
            eob_reg    <= end_of_batch;
            scan_reg   <= '0;
            rd_idx_reg <= '0;
        end
        if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + SLOT_AW'(1);
        end
        if (cmd.found_set)
        begin
            found_slot_reg <= scan_reg;
            found_camp_reg <= slot_rdata[SLOT_W-1:KEY_W];
        end
        if (cmd.out_inc)
        begin
            rd_idx_reg <= rd_idx_reg + CAMP_W'(1);
        end
        if (cmd.out_emit)
        begin
            campaign_reg <= rd_idx_reg;
            total_reg    <= out_total;
            dropped_reg  <= drop_reg;
            last_reg     <= status.out_last;
        end
    end

    assign result_valid     = result_valid_reg;
    assign campaign         = campaign_reg;
    assign attributed_total = total_reg;
    assign dropped_flag     = dropped_reg;
    assign last_total       = last_reg;

    `LTA_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= FILL_W'(KEY_SLOTS),
        "key fill count beyond table size")
    `LTA_ASSERT_SAME(a_no_alloc_when_full, cmd.src_write && !found_reg,
        fill_reg != FILL_W'(KEY_SLOTS), "slot allocated in a full table")
    `LTA_ASSERT_SAME(a_sum_rmw_order, cmd.sum_wr, $past(cmd.sum_rd),
        "total written without a prior read")
    `LTA_ASSERT_NEXT(a_word_spacing, result_valid_reg, !result_valid_reg,
        "readout words not spaced by a cycle")

endmodule
